/* hdl/mec_pkg.sv */
// mec_pkg: shared types and constants of the masked edge centroid block
// no dependencies; used by every module under hdl

package mec_pkg;

  localparam int unsigned CoordW  = 12;  // pixel row and column width
  localparam int unsigned LevelW  = 8;   // edge and background level width
  localparam int unsigned SumW    = 36;  // running coordinate sum width
  localparam int unsigned CountW  = 25;  // hit counter width, holds 2**24
  localparam int unsigned EndW    = 13;  // exclusive window end width
  localparam int unsigned QuotW   = CoordW;          // quotient bits per mean
  localparam int unsigned StepW   = $clog2(QuotW);   // divider step counter
  localparam int unsigned CfgIdxW = 2;

  // register reset values
  localparam logic [LevelW-1:0] ThresholdReset = LevelW'(128);
  localparam logic [CoordW-1:0] ColStartReset  = CoordW'(200);
  localparam logic [EndW-1:0]   ColEndReset    = EndW'(4096);

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgColStart  = 2'd1,
    CfgColEnd    = 2'd2,
    CfgUnused    = 2'd3
  } mec_cfg_e;

  typedef struct packed {
    logic [LevelW-1:0] edge_level;
    logic [LevelW-1:0] background_level;
    logic [CoordW-1:0] pixel_row;
    logic [CoordW-1:0] pixel_column;
    logic              end_of_frame;
  } mec_in_t;

  typedef struct packed {
    logic [CoordW-1:0] centre_x;
    logic [CoordW-1:0] centre_y;
    logic [CountW-1:0] hit_count;
    logic              frame_empty;
  } mec_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // pixel word taken this cycle
    logic load;    // frame closed: hand sums to divider, clear accumulators
    logic step;    // one restoring division step
  } mec_cmd_t;

endpackage

/* hdl/mec_ctrl.sv */
// mec_ctrl: handshake and sequencing state machine of the centroid block
// depends on mec_pkg

module mec_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_eof_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mec_pkg::mec_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StHold = 3'b100
  } mec_state_e;

  mec_state_e                    state_q, state_d;
  logic [mec_pkg::StepW-1:0]     step_q, step_d;
  logic                          accept;

  // end-of-frame words wait until the divider and result register are free
  assign in_stall_o  = in_eof_i && (state_q != StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StHold);

  assign cmd_o.accept = accept;
  assign cmd_o.load   = accept && in_eof_i;
  assign cmd_o.step   = (state_q == StDiv);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (accept && in_eof_i) begin
          state_d = StDiv;
          step_d  = '0;
        end
      end
      StDiv: begin
        if (step_q == mec_pkg::StepW'(mec_pkg::QuotW - 1)) begin
          state_d = StHold;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      StHold: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

/* hdl/mec_datapath.sv */
// mec_datapath: config registers, hit test, accumulators, shared-divisor
// restoring divider and result register; depends on mec_pkg

module mec_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [mec_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mec_pkg::EndW-1:0]        cfg_data_i,
  input  mec_pkg::mec_in_t                in_word_i,
  input  mec_pkg::mec_cmd_t               cmd_i,
  output mec_pkg::mec_out_t               out_word_o
);

  logic [mec_pkg::LevelW-1:0] thr_q;
  logic [mec_pkg::CoordW-1:0] col_start_q;
  logic [mec_pkg::EndW-1:0]   col_end_q;

  logic [mec_pkg::SumW-1:0]   col_sum_q, col_sum_d, col_sum_new;
  logic [mec_pkg::SumW-1:0]   row_sum_q, row_sum_d, row_sum_new;
  logic [mec_pkg::CountW-1:0] hits_q, hits_d, hits_new;
  logic                       hit;

  logic [mec_pkg::SumW-1:0]   rem_x_q, rem_y_q;
  logic [mec_pkg::SumW-1:0]   dvs_q;
  logic [mec_pkg::QuotW-1:0]  qx_q, qy_q;
  logic [mec_pkg::CountW-1:0] count_q;
  logic                       empty_q;
  logic                       ge_x, ge_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= mec_pkg::ThresholdReset;
      col_start_q <= mec_pkg::ColStartReset;
      col_end_q   <= mec_pkg::ColEndReset;
    end else if (cfg_valid_i) begin
      unique case (mec_pkg::mec_cfg_e'(cfg_index_i))
        mec_pkg::CfgThreshold: thr_q       <= cfg_data_i[mec_pkg::LevelW-1:0];
        mec_pkg::CfgColStart:  col_start_q <= cfg_data_i[mec_pkg::CoordW-1:0];
        mec_pkg::CfgColEnd:    col_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // coordinates are 12 bits, so the frame size bounds always hold;
  // counting stops once the hit counter reaches 2**24
  assign hit = (in_word_i.pixel_column >= col_start_q)
            && ({1'b0, in_word_i.pixel_column} < col_end_q)
            && (in_word_i.background_level < thr_q)
            && (in_word_i.edge_level != '0)
            && !hits_q[mec_pkg::CountW-1];

  always_comb begin
    col_sum_new = col_sum_q;
    row_sum_new = row_sum_q;
    hits_new    = hits_q;
    if (hit) begin
      col_sum_new = col_sum_q + mec_pkg::SumW'(in_word_i.pixel_column);
      row_sum_new = row_sum_q + mec_pkg::SumW'(in_word_i.pixel_row);
      hits_new    = hits_q + 1'b1;
    end
    col_sum_d = col_sum_q;
    row_sum_d = row_sum_q;
    hits_d    = hits_q;
    if (cmd_i.load) begin
      col_sum_d = '0;
      row_sum_d = '0;
      hits_d    = '0;
    end else if (cmd_i.accept) begin
      col_sum_d = col_sum_new;
      row_sum_d = row_sum_new;
      hits_d    = hits_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_sum_q <= '0;
      row_sum_q <= '0;
      hits_q    <= '0;
    end else begin
      col_sum_q <= col_sum_d;
      row_sum_q <= row_sum_d;
      hits_q    <= hits_d;
    end
  end

  // restoring division, one quotient bit per step for both means
  assign ge_x = (rem_x_q >= dvs_q);
  assign ge_y = (rem_y_q >= dvs_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_x_q <= col_sum_new;
      rem_y_q <= row_sum_new;
      dvs_q   <= {hits_new, {(mec_pkg::QuotW-1){1'b0}}};
      count_q <= hits_new;
      empty_q <= (hits_new == '0);
      qx_q    <= '0;
      qy_q    <= '0;
    end else if (cmd_i.step) begin
      if (ge_x) rem_x_q <= rem_x_q - dvs_q;
      if (ge_y) rem_y_q <= rem_y_q - dvs_q;
      dvs_q <= dvs_q >> 1;
      qx_q  <= {qx_q[mec_pkg::QuotW-2:0], ge_x};
      qy_q  <= {qy_q[mec_pkg::QuotW-2:0], ge_y};
    end
  end

  assign out_word_o.centre_x    = empty_q ? '0 : qx_q;
  assign out_word_o.centre_y    = empty_q ? '0 : qy_q;
  assign out_word_o.hit_count   = count_q;
  assign out_word_o.frame_empty = empty_q;

endmodule

/* hdl/masked_edge_centroid.sv */
// masked_edge_centroid: top level, joins controller and datapath
// depends on mec_pkg, mec_ctrl, mec_datapath
//
// usage
// - in channel: one pixel word per accepted cycle (in_valid_i high, in_stall_o
//   low); ordinary pixels are taken every cycle, one word per clock
// - a pixel is a hit when its column is inside [column_start, column_end),
//   its background level is below the threshold and its edge level is nonzero
// - the word flagged end_of_frame closes the frame: its sums go to a
//   restoring divider that produces one bit of both means per cycle
// - out_valid_o rises once the divider has made its 12 steps (set by the
//   12-bit quotient) after the end-of-frame word is taken
// - pixels of the next frame keep flowing during division and while the
//   result waits; only the next end-of-frame word is stalled until the
//   previous result word has been taken
// - out channel: the result word holds while out_stall_i is high
// - empty frame: centre outputs zero, hit_count zero, frame_empty set
// - cfg channel: cfg_ready_o is always high; index 0 threshold, 1 window
//   start, 2 window end, other indexes ignored; write only while idle
// - reset: sums cleared, registers at 128 / 200 / 4096, no result pending

module masked_edge_centroid (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mec_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mec_pkg::EndW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  mec_pkg::mec_in_t            in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output mec_pkg::mec_out_t           out_word_o
);

  mec_pkg::mec_cmd_t cmd;

  // registers are plain flops, a write never waits
  assign cfg_ready_o = 1'b1;

  mec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_eof_i    (in_word_i.end_of_frame),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  mec_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .out_word_o  (out_word_o)
  );

endmodule
